// ----- rtl/csl_pkg.sv -----
package csl_pkg;

   localparam int MAX_ROW_LENGTH_DEFAULT = 1024;

   localparam int HEIGHT_W    = 32;
   localparam int LOW_W       = 31;
   localparam int ROW_W       = 16;
   localparam int COL_OUT_W   = 10;
   localparam int RLEN_W      = 11;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 31;

   localparam logic [RLEN_W-1:0] ROW_LENGTH_RESET  = RLEN_W'(1024);
   localparam logic [ROW_W-1:0]  ROW_COUNT_RESET   = ROW_W'(1024);
   localparam logic [LOW_W-1:0]  HORIZ_LIMIT_RESET = LOW_W'(179);
   localparam logic [LOW_W-1:0]  VERT_LIMIT_RESET  = LOW_W'(179);

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ROW_LENGTH,
      REG_ROW_COUNT,
      REG_HORIZ_LIMIT,
      REG_VERT_LIMIT
   } csr_index_type;

   // x is the later cell of a pair, y the neighbour it is compared against
   typedef struct packed {
      logic signed [HEIGHT_W-1:0] x_h;
      logic [LOW_W-1:0]           x_low;
      logic signed [HEIGHT_W-1:0] y_h;
      logic [LOW_W-1:0]           y_low;
   } pair_type;

   // horizontally final cells leaving the horizontal stage
   typedef struct packed {
      logic                       valid;
      logic                       has_above;
      logic                       last_row;
      logic                       grid_end;
      logic [ROW_W-1:0]           row;
      logic                       ev0_valid;
      logic signed [HEIGHT_W-1:0] ev0_h;
      logic [LOW_W-1:0]           ev0_low;
      logic                       ev1_valid;
      logic signed [HEIGHT_W-1:0] ev1_h;
      logic [LOW_W-1:0]           ev1_low;
   } evt_type;

   // up to four results of one item, slot order: above held, held, above new, new
   typedef struct packed {
      logic [3:0]                 mask;
      logic [ROW_W-1:0]           row;
      logic                       grid_end;
      logic [3:0][HEIGHT_W-1:0]   h;
      logic [3:0][LOW_W-1:0]      low;
   } bundle_type;

   function automatic logic [LOW_W-1:0] sat_low(input logic [LOW_W+2:0] sum);
      logic [LOW_W-1:0] r;
      if (sum > (LOW_W+3)'({LOW_W{1'b1}})) begin
         r = '1;
      end else begin
         r = sum[LOW_W-1:0];
      end
      return r;
   endfunction

   function automatic pair_type slope_cut(input pair_type p, input logic [LOW_W-1:0] lim);
      logic signed [HEIGHT_W+1:0] over_x;
      logic signed [HEIGHT_W+1:0] over_y;
      logic [LOW_W+2:0]           sum;
      pair_type                   r;
      r      = p;
      over_x = (HEIGHT_W+2)'(p.x_h) - (HEIGHT_W+2)'(p.y_h) - $signed({3'b000, lim});
      over_y = (HEIGHT_W+2)'(p.y_h) - (HEIGHT_W+2)'(p.x_h) - $signed({3'b000, lim});
      sum    = '0;
      if (over_x > 0) begin
         sum     = {3'b000, p.x_low} + (LOW_W+3)'(over_x);
         r.x_low = sat_low(sum);
         r.x_h   = p.y_h + $signed({1'b0, lim});
      end else if (over_y > 0) begin
         sum     = {3'b000, p.y_low} + (LOW_W+3)'(over_y);
         r.y_low = sat_low(sum);
         r.y_h   = p.x_h + $signed({1'b0, lim});
      end
      return r;
   endfunction

endpackage

// ----- rtl/critical_slope_limiter.sv -----
// Critical slope limiter over a raster stream of terrain heights (signed, 8 fraction bits).
// Each cell is lowered where it stands more than horiz_limit above its left or right
// neighbour, then more than vert_limit above the cell above or below; a cell leaves on rsp
// once final, with row, column, final height and saturated total lowering. A cell emerges
// when the next cell of its row arrives or when its row closes; outside the last row the
// cell leaving is the one above. Items overlap in the pipeline; rsp carries one result per
// clock while rsp_stall is low, so an item closing a row (two results, four on a last row
// with a row above) holds req until its results have left. A result passes the input
// register, horizontal stage, vertical stage with the line store read, and result register.
// The line store is two banks of (MAX_ROW_LENGTH+1)/2 entries split by column
// parity, with no clearing after reset. Write csr registers only while the block is idle.
module critical_slope_limiter import csl_pkg::*; #(
   parameter int  MAX_ROW_LENGTH = MAX_ROW_LENGTH_DEFAULT,
   localparam int COL_W = $clog2(MAX_ROW_LENGTH)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [HEIGHT_W-1:0] req_height_in,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [ROW_W-1:0]           rsp_cell_row,
   output logic [COL_OUT_W-1:0]       rsp_cell_col,
   output logic signed [HEIGHT_W-1:0] rsp_height_out,
   output logic [LOW_W-1:0]           rsp_lowered_by,
   output logic                       rsp_run_last,
   output logic                       rsp_grid_done
);

   logic [RLEN_W-1:0] row_length_ff, row_length_in;
   logic [ROW_W-1:0]  row_count_ff, row_count_in;
   logic [LOW_W-1:0]  horiz_limit_ff, horiz_limit_in;
   logic [LOW_W-1:0]  vert_limit_ff, vert_limit_in;

   evt_type           evt;
   logic [COL_W-1:0]  evt_col;
   logic [COL_W-1:0]  rd_col;
   logic              evt_take;
   logic              out_free;
   logic              out_load;
   bundle_type        bundle;
   logic [COL_W-1:0]  bundle_col;

   assign csr_ready = 1'b1;

   always_comb begin
      row_length_in  = row_length_ff;
      row_count_in   = row_count_ff;
      horiz_limit_in = horiz_limit_ff;
      vert_limit_in  = vert_limit_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            REG_ROW_LENGTH:  row_length_in  = csr_wdata[RLEN_W-1:0];
            REG_ROW_COUNT:   row_count_in   = csr_wdata[ROW_W-1:0];
            REG_HORIZ_LIMIT: horiz_limit_in = csr_wdata[LOW_W-1:0];
            REG_VERT_LIMIT:  vert_limit_in  = csr_wdata[LOW_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff  <= ROW_LENGTH_RESET;
         row_count_ff   <= ROW_COUNT_RESET;
         horiz_limit_ff <= HORIZ_LIMIT_RESET;
         vert_limit_ff  <= VERT_LIMIT_RESET;
      end else begin
         row_length_ff  <= row_length_in;
         row_count_ff   <= row_count_in;
         horiz_limit_ff <= horiz_limit_in;
         vert_limit_ff  <= vert_limit_in;
      end
   end

   csl_horiz #(
      .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
   ) u_horiz (
      .clock         (clock),
      .reset         (reset),
      .row_length    (row_length_ff),
      .row_count     (row_count_ff),
      .horiz_limit   (horiz_limit_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_height_in (req_height_in),
      .evt_take      (evt_take),
      .evt           (evt),
      .evt_col       (evt_col),
      .rd_col        (rd_col)
   );

   csl_vert #(
      .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
   ) u_vert (
      .clock      (clock),
      .reset      (reset),
      .vert_limit (vert_limit_ff),
      .evt        (evt),
      .evt_col    (evt_col),
      .rd_col     (rd_col),
      .evt_take   (evt_take),
      .out_free   (out_free),
      .out_load   (out_load),
      .bundle     (bundle),
      .bundle_col (bundle_col)
   );

   csl_out #(
      .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
   ) u_out (
      .clock          (clock),
      .reset          (reset),
      .out_load       (out_load),
      .bundle         (bundle),
      .bundle_col     (bundle_col),
      .out_free       (out_free),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_row   (rsp_cell_row),
      .rsp_cell_col   (rsp_cell_col),
      .rsp_height_out (rsp_height_out),
      .rsp_lowered_by (rsp_lowered_by),
      .rsp_run_last   (rsp_run_last),
      .rsp_grid_done  (rsp_grid_done)
   );

endmodule

// ----- rtl/csl_ram.sv -----
module csl_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 2,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/csl_horiz.sv -----
module csl_horiz import csl_pkg::*; #(
   parameter int  MAX_ROW_LENGTH = MAX_ROW_LENGTH_DEFAULT,
   localparam int COL_W = $clog2(MAX_ROW_LENGTH),
   localparam int LEN_W = $clog2(MAX_ROW_LENGTH + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [RLEN_W-1:0]          row_length,
   input  logic [ROW_W-1:0]           row_count,
   input  logic [LOW_W-1:0]           horiz_limit,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [HEIGHT_W-1:0] req_height_in,
   input  logic                       evt_take,
   output evt_type                    evt,
   output logic [COL_W-1:0]           evt_col,
   output logic [COL_W-1:0]           rd_col
);

   logic [LEN_W-1:0]           len_eff;
   logic [COL_W-1:0]           last_col;
   logic [COL_W-1:0]           col;
   logic [ROW_W-1:0]           rows_m1;
   logic                       last_row;
   logic                       row_end;
   logic                       accept;
   logic                       s0_move;

   logic [COL_W-1:0]           col_count_ff, col_count_in;
   logic [ROW_W-1:0]           row_index_ff, row_index_in;

   logic                       s0_valid_ff, s0_valid_in;
   logic signed [HEIGHT_W-1:0] s0_h_ff;
   logic [COL_W-1:0]           s0_col_ff;
   logic [ROW_W-1:0]           s0_row_ff;
   logic                       s0_last_row_ff;
   logic                       s0_row_end_ff;

   logic signed [HEIGHT_W-1:0] held_h_ff, held_h_in;
   logic [LOW_W-1:0]           held_low_ff, held_low_in;

   pair_type                   pair_in;
   pair_type                   pair_out;

   evt_type                    evt_ff, evt_in;
   logic [COL_W-1:0]           evt_col_ff, evt_col_in;

   // effective grid shape
   always_comb begin
      if (row_length == '0) begin
         len_eff = LEN_W'(1);
      end else if (32'(row_length) > 32'(MAX_ROW_LENGTH)) begin
         len_eff = LEN_W'(MAX_ROW_LENGTH);
      end else begin
         len_eff = LEN_W'(row_length);
      end
      last_col = COL_W'(len_eff - 1'b1);
      col      = (col_count_ff > last_col) ? last_col : col_count_ff;
      rows_m1  = (row_count == '0) ? '0 : row_count - 1'b1;
      last_row = row_index_ff >= rows_m1;
      row_end  = col == last_col;
   end

   assign s0_move   = s0_valid_ff && (!evt_ff.valid || evt_take);
   assign req_stall = s0_valid_ff && !s0_move;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      col_count_in = col_count_ff;
      row_index_in = row_index_ff;
      if (accept) begin
         if (row_end) begin
            col_count_in = '0;
            row_index_in = last_row ? '0 : row_index_ff + 1'b1;
         end else begin
            col_count_in = col + 1'b1;
         end
      end
      if (accept) begin
         s0_valid_in = 1'b1;
      end else if (s0_move) begin
         s0_valid_in = 1'b0;
      end else begin
         s0_valid_in = s0_valid_ff;
      end
   end

   // horizontal pass against the held cell
   always_comb begin
      pair_in.x_h   = s0_h_ff;
      pair_in.x_low = '0;
      pair_in.y_h   = held_h_ff;
      pair_in.y_low = held_low_ff;
      pair_out      = (s0_col_ff != '0) ? slope_cut(pair_in, horiz_limit) : pair_in;
      held_h_in     = s0_move ? pair_out.x_h : held_h_ff;
      held_low_in   = s0_move ? pair_out.x_low : held_low_ff;
   end

   always_comb begin
      evt_in     = evt_ff;
      evt_col_in = evt_col_ff;
      if (s0_move) begin
         evt_in.valid     = 1'b1;
         evt_in.has_above = s0_row_ff != '0;
         evt_in.last_row  = s0_last_row_ff;
         evt_in.grid_end  = s0_last_row_ff && s0_row_end_ff;
         evt_in.row       = s0_row_ff;
         evt_in.ev0_valid = s0_col_ff != '0;
         evt_in.ev0_h     = pair_out.y_h;
         evt_in.ev0_low   = pair_out.y_low;
         evt_in.ev1_valid = s0_row_end_ff;
         evt_in.ev1_h     = pair_out.x_h;
         evt_in.ev1_low   = pair_out.x_low;
         evt_col_in       = s0_col_ff;
      end else if (evt_take) begin
         evt_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_index_ff <= '0;
         s0_valid_ff  <= 1'b0;
         held_h_ff    <= '0;
         held_low_ff  <= '0;
         evt_ff.valid <= 1'b0;
      end else begin
         col_count_ff <= col_count_in;
         row_index_ff <= row_index_in;
         s0_valid_ff  <= s0_valid_in;
         held_h_ff    <= held_h_in;
         held_low_ff  <= held_low_in;
         evt_ff       <= evt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s0_h_ff        <= req_height_in;
         s0_col_ff      <= col;
         s0_row_ff      <= row_index_ff;
         s0_last_row_ff <= last_row;
         s0_row_end_ff  <= row_end;
      end
      evt_col_ff <= evt_col_in;
   end

   // line store read follows the item that will sit in the event register
   assign rd_col  = (evt_ff.valid && !evt_take) ? evt_col_ff : s0_col_ff;
   assign evt     = evt_ff;
   assign evt_col = evt_col_ff;

   a_evt_hold: assert property (@(posedge clock) disable iff (reset)
      evt_ff.valid && !evt_take |=> evt_ff.valid && $stable(evt_col_ff))
      else $error("event register lost a waiting item");

endmodule

// ----- rtl/csl_vert.sv -----
module csl_vert import csl_pkg::*; #(
   parameter int  MAX_ROW_LENGTH = MAX_ROW_LENGTH_DEFAULT,
   localparam int COL_W      = $clog2(MAX_ROW_LENGTH),
   localparam int BANK_DEPTH = (MAX_ROW_LENGTH + 1) / 2,
   localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1,
   localparam int LINE_W     = HEIGHT_W + LOW_W
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [LOW_W-1:0]   vert_limit,
   input  evt_type            evt,
   input  logic [COL_W-1:0]   evt_col,
   input  logic [COL_W-1:0]   rd_col,
   output logic               evt_take,
   input  logic               out_free,
   output logic               out_load,
   output bundle_type         bundle,
   output logic [COL_W-1:0]   bundle_col
);

   logic [BANK_AW-1:0] rd_addr [2];
   logic [BANK_AW-1:0] wr_addr [2];
   logic [LINE_W-1:0]  wr_data [2];
   logic [LINE_W-1:0]  ram_q   [2];
   logic [LINE_W-1:0]  line_q  [2];
   logic [LINE_W-1:0]  byp_data_ff [2];
   logic [1:0]         byp_ff, byp_in;
   logic [1:0]         wr_en;

   logic [LINE_W-1:0]  above0, above1;
   pair_type           pair0, pair1, cut0, cut1;
   logic [3:0]         mask;

   // line store in two banks split by column parity
   for (genvar b = 0; b < 2; b++) begin : g_bank
      assign rd_addr[b] = (rd_col[0] == 1'(b)) ? BANK_AW'(rd_col >> 1)
                                               : BANK_AW'((rd_col - 1'b1) >> 1);
      assign wr_addr[b] = (evt_col[0] == 1'(b)) ? BANK_AW'(evt_col >> 1)
                                                : BANK_AW'((evt_col - 1'b1) >> 1);
      assign wr_en[b]   = evt_take && ((evt_col[0] == 1'(b)) ? evt.ev1_valid : evt.ev0_valid);
      assign wr_data[b] = (evt_col[0] == 1'(b)) ? {cut1.x_h, cut1.x_low}
                                                : {cut0.x_h, cut0.x_low};
      assign byp_in[b]  = wr_en[b] && (wr_addr[b] == rd_addr[b]);
      assign line_q[b]  = byp_ff[b] ? byp_data_ff[b] : ram_q[b];

      csl_ram #(
         .WIDTH (LINE_W),
         .DEPTH (BANK_DEPTH)
      ) u_line (
         .clock   (clock),
         .wr_en   (wr_en[b]),
         .wr_addr (wr_addr[b]),
         .wr_data (wr_data[b]),
         .rd_addr (rd_addr[b]),
         .rd_data (ram_q[b])
      );

      always_ff @(posedge clock) begin
         byp_data_ff[b] <= wr_data[b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= '0;
      end else begin
         byp_ff <= byp_in;
      end
   end

   // vertical pass against the row above
   always_comb begin
      above1      = evt_col[0] ? line_q[1] : line_q[0];
      above0      = evt_col[0] ? line_q[0] : line_q[1];
      pair0.x_h   = evt.ev0_h;
      pair0.x_low = evt.ev0_low;
      pair0.y_h   = above0[LINE_W-1:LOW_W];
      pair0.y_low = above0[LOW_W-1:0];
      pair1.x_h   = evt.ev1_h;
      pair1.x_low = evt.ev1_low;
      pair1.y_h   = above1[LINE_W-1:LOW_W];
      pair1.y_low = above1[LOW_W-1:0];
      cut0        = evt.has_above ? slope_cut(pair0, vert_limit) : pair0;
      cut1        = evt.has_above ? slope_cut(pair1, vert_limit) : pair1;
   end

   always_comb begin
      mask[0] = evt.valid && evt.ev0_valid && evt.has_above;
      mask[1] = evt.valid && evt.ev0_valid && evt.last_row;
      mask[2] = evt.valid && evt.ev1_valid && evt.has_above;
      mask[3] = evt.valid && evt.ev1_valid && evt.last_row;
      bundle.mask     = mask;
      bundle.row      = evt.row;
      bundle.grid_end = evt.grid_end;
      bundle.h[0]     = cut0.y_h;
      bundle.low[0]   = cut0.y_low;
      bundle.h[1]     = cut0.x_h;
      bundle.low[1]   = cut0.x_low;
      bundle.h[2]     = cut1.y_h;
      bundle.low[2]   = cut1.y_low;
      bundle.h[3]     = cut1.x_h;
      bundle.low[3]   = cut1.x_low;
   end

   assign evt_take   = evt.valid && ((mask == '0) || out_free);
   assign out_load   = evt_take && (mask != '0);
   assign bundle_col = evt_col;

   a_bank_split: assert property (@(posedge clock) disable iff (reset)
      evt_take && evt.ev0_valid && evt.ev1_valid |-> wr_en == 2'b11)
      else $error("row end did not write both line banks");

endmodule

// ----- rtl/csl_out.sv -----
module csl_out import csl_pkg::*; #(
   parameter int  MAX_ROW_LENGTH = MAX_ROW_LENGTH_DEFAULT,
   localparam int COL_W = $clog2(MAX_ROW_LENGTH)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       out_load,
   input  bundle_type                 bundle,
   input  logic [COL_W-1:0]           bundle_col,
   output logic                       out_free,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [ROW_W-1:0]           rsp_cell_row,
   output logic [COL_OUT_W-1:0]       rsp_cell_col,
   output logic signed [HEIGHT_W-1:0] rsp_height_out,
   output logic [LOW_W-1:0]           rsp_lowered_by,
   output logic                       rsp_run_last,
   output logic                       rsp_grid_done
);

   logic [3:0]               mask_ff, mask_in;
   logic [ROW_W-1:0]         row_ff;
   logic                     grid_end_ff;
   logic [3:0][HEIGHT_W-1:0] h_ff;
   logic [3:0][LOW_W-1:0]    low_ff;
   logic [COL_W-1:0]         col_ff;

   logic                     xfer;
   logic                     last;
   logic [1:0]               sel;

   assign rsp_valid = |mask_ff;
   assign xfer      = rsp_valid && !rsp_stall;
   assign last      = (mask_ff & (mask_ff - 4'd1)) == '0;
   assign out_free  = !rsp_valid || (last && !rsp_stall);

   always_comb begin
      if (out_load) begin
         mask_in = bundle.mask;
      end else if (xfer) begin
         mask_in = mask_ff & (mask_ff - 4'd1);
      end else begin
         mask_in = mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         row_ff      <= bundle.row;
         grid_end_ff <= bundle.grid_end;
         h_ff        <= bundle.h;
         low_ff      <= bundle.low;
         col_ff      <= bundle_col;
      end
   end

   // lowest pending slot goes first
   always_comb begin
      priority if (mask_ff[0]) begin
         sel = 2'd0;
      end else if (mask_ff[1]) begin
         sel = 2'd1;
      end else if (mask_ff[2]) begin
         sel = 2'd2;
      end else begin
         sel = 2'd3;
      end
   end

   assign rsp_cell_row   = sel[0] ? row_ff : row_ff - 1'b1;
   assign rsp_cell_col   = sel[1] ? COL_OUT_W'(col_ff) : COL_OUT_W'(col_ff - 1'b1);
   assign rsp_height_out = $signed(h_ff[sel]);
   assign rsp_lowered_by = low_ff[sel];
   assign rsp_run_last   = last;
   assign rsp_grid_done  = last && grid_end_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> !rsp_valid || (rsp_run_last && !rsp_stall))
      else $error("result register overwritten while results pending");

   a_run_cont: assert property (@(posedge clock) disable iff (reset)
      xfer && !rsp_run_last |=> rsp_valid)
      else $error("item results broken off before last");

   a_done_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_grid_done |-> sel[0])
      else $error("grid end flagged on a cell of the row above");

endmodule
